[rtl/ipu_pkg.sv]
// Package for the linear interpolation upsampler.
// Holds register widths, register indexes, reset values and the command and
// status structs between the controller and the datapath. No dependencies.
package ipu_pkg;

   localparam int DEFAULT_MAX_CHANNELS = 2;
   localparam int DEFAULT_SAMPLE_BITS = 16;

   localparam int FACTOR_W = 6;
   localparam int CHAN_W = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_FACTOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS = 1'd1;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 6'd1;
   localparam logic [CHAN_W-1:0] CHANNELS_RESET = 2'd2;

   typedef struct packed {
      logic load;        // input word accepted: capture it and start the dividers
      logic step;        // emit one interpolated word and advance
      logic emit_final;  // emit the current frame itself
      logic tag_last;    // mark the emitted word as the last of its run
   } cmd_type;

   typedef struct packed {
      logic div_busy;    // dividers still iterating
      logic last_step;   // step counter is at factor - 1
      logic can_load;    // output register can take a word this cycle
   } status_type;

endpackage

[rtl/ipu_req_if.sv]
// Request channel of the upsampler: one input frame per word.
// Depends on nothing; the sample width is a parameter.
interface ipu_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   logic                          first_frame;
   logic                          last_frame;

   modport source (
      output valid, left_sample, right_sample, first_frame, last_frame,
      input  ready
   );
   modport sink (
      input  valid, left_sample, right_sample, first_frame, last_frame,
      output ready
   );
endinterface

[rtl/ipu_rsp_if.sv]
// Response channel of the upsampler: one output frame per word.
// Depends on nothing; the sample width is a parameter.
interface ipu_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic                          last_of_run;

   modport source (
      output valid, left_out, right_out, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, left_out, right_out, last_of_run,
      output ready
   );
endinterface

[rtl/ipu_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used by the upsampler datapath once per channel; no package dependencies.
module ipu_div #(
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder,
   output logic                  busy
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_sub = trial - {1'b0, divisor};
      fits = (trial >= {1'b0, divisor});
      count_in = count_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (start) begin
         count_in = CNT_W'(DIVIDEND_W);
         quo_in = dividend;
         rem_in = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         // The partial remainder stays below the divisor, so the trial is
         // below twice the divisor and one subtraction settles it.
         rem_in = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff;
   assign remainder = rem_ff;
   assign busy = (count_ff != '0);

endmodule

[rtl/ipu_dp.sv]
// Datapath of the upsampler: configuration registers, frame registers, one
// divider and one step accumulator per channel, step counter, output register.
// Depends on ipu_pkg and ipu_div.
module ipu_dp #(
   parameter int MAX_CHANNELS = 2,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [ipu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ipu_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  ipu_pkg::cmd_type                    cmd,
   output ipu_pkg::status_type                 status,
   input  logic signed [SAMPLE_BITS-1:0]       left_sample,
   input  logic signed [SAMPLE_BITS-1:0]       right_sample,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       left_out,
   output logic signed [SAMPLE_BITS-1:0]       right_out,
   output logic                                last_of_run
);

   localparam int FW = ipu_pkg::FACTOR_W;
   localparam int CW = ipu_pkg::CHAN_W;
   localparam int SB = SAMPLE_BITS;
   localparam int LANES = MAX_CHANNELS;

   logic [FW-1:0] factor_ff, factor_in;
   logic [CW-1:0] chan_ff, chan_in;
   logic [FW-1:0] factor_eff;
   logic          two_ch;

   logic [FW-1:0] k_ff, k_in;

   logic signed [SB-1:0] sample_in [LANES];
   logic signed [SB-1:0] cur_ff    [LANES];
   logic signed [SB-1:0] base_ff   [LANES];
   logic signed [SB-1:0] interp    [LANES];
   logic [LANES-1:0]     busy;

   logic                 out_valid_ff, out_valid_in;
   logic signed [SB-1:0] left_ff, left_in;
   logic signed [SB-1:0] right_ff, right_in;
   logic                 tag_ff, tag_in;
   logic                 out_load;

   // Configuration registers.
   always_comb begin
      factor_in = factor_ff;
      chan_in = chan_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ipu_pkg::CSR_FACTOR:   factor_in = csr_write_data[FW-1:0];
            ipu_pkg::CSR_CHANNELS: chan_in = csr_write_data[CW-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= ipu_pkg::FACTOR_RESET;
         chan_ff <= ipu_pkg::CHANNELS_RESET;
      end else begin
         factor_ff <= factor_in;
         chan_ff <= chan_in;
      end
   end

   // A factor of zero counts as one; channel counts above two clamp to two.
   assign factor_eff = (factor_ff == '0) ? FW'(1) : factor_ff;
   assign two_ch = (MAX_CHANNELS > 1) && (chan_ff >= CW'(2));

   assign sample_in[0] = left_sample;
   if (LANES > 1) begin : g_right_in
      assign sample_in[LANES-1] = right_sample;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic signed [SB:0]   diff;
      logic [SB:0]          mag;
      logic [SB-1:0]        quo;
      logic [FW-1:0]        rem;
      logic                 neg_ff, neg_in;
      logic [SB-1:0]        q_ff, q_in;
      logic [FW-1:0]        r_ff, r_in;
      logic [FW:0]          r_sum;
      logic [FW:0]          r_sub;
      logic                 wrap;
      logic signed [SB:0]   delta;
      logic signed [SB:0]   value;
      logic signed [SB-1:0] cur_in;
      logic signed [SB-1:0] base_in;

      assign diff = {sample_in[i][SB-1], sample_in[i]} - {cur_ff[i][SB-1], cur_ff[i]};
      assign mag = diff[SB] ? (-diff) : diff;

      ipu_div #(
         .DIVIDEND_W(SB),
         .DIVISOR_W (FW)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.load),
         .dividend (mag[SB-1:0]),
         .divisor  (factor_eff),
         .quotient (quo),
         .remainder(rem),
         .busy     (busy[i])
      );

      // |diff| * k = q * factor + r is kept by adding the quotient and
      // remainder of |diff| / factor at each step, with one carry.
      always_comb begin
         r_sum = {1'b0, r_ff} + {1'b0, rem};
         r_sub = r_sum - {1'b0, factor_eff};
         wrap = (r_sum >= {1'b0, factor_eff});
         delta = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
         value = {base_ff[i][SB-1], base_ff[i]} + delta;
         interp[i] = value[SB-1:0];

         cur_in = cur_ff[i];
         base_in = base_ff[i];
         neg_in = neg_ff;
         q_in = q_ff;
         r_in = r_ff;
         if (cmd.load) begin
            cur_in = sample_in[i];
            base_in = cur_ff[i];
            neg_in = diff[SB];
            q_in = '0;
            r_in = '0;
         end else if (cmd.step) begin
            q_in = q_ff + quo + SB'(wrap);
            r_in = wrap ? r_sub[FW-1:0] : r_sum[FW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cur_ff[i] <= '0;
         end else begin
            cur_ff[i] <= cur_in;
         end
      end

      always_ff @(posedge clock) begin
         base_ff[i] <= base_in;
         neg_ff <= neg_in;
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   // Step counter k.
   always_comb begin
      k_in = k_ff;
      if (cmd.load) begin
         k_in = '0;
      end else if (cmd.step) begin
         k_in = k_ff + FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
   end

   // Output register; it takes a new word when it is empty or the old one leaves.
   assign out_load = cmd.step | cmd.emit_final;

   always_comb begin
      out_valid_in = out_load | (out_valid_ff & ~rsp_ready);
      left_in = left_ff;
      right_in = right_ff;
      tag_in = tag_ff;
      if (out_load) begin
         left_in = cmd.emit_final ? cur_ff[0] : interp[0];
         right_in = '0;
         if (two_ch) begin
            right_in = cmd.emit_final ? cur_ff[LANES-1] : interp[LANES-1];
         end
         tag_in = cmd.tag_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      right_ff <= right_in;
      tag_ff <= tag_in;
   end

   assign status.div_busy = |busy;
   assign status.last_step = (k_ff == (factor_eff - FW'(1)));
   assign status.can_load = ~out_valid_ff | rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign left_out = left_ff;
   assign right_out = right_ff;
   assign last_of_run = tag_ff;

endmodule

[rtl/ipu_ctrl.sv]
// Controller of the upsampler: sequences accept, divide, interpolation steps
// and the final word. Depends on ipu_pkg for the command and status structs.
module ipu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_first,
   input  logic                req_last,
   output logic                req_ready,
   input  ipu_pkg::status_type status,
   output ipu_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_STEP  = 2'd2;
   localparam logic [1:0] ST_FINAL = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       last_ff, last_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      last_in = last_ff;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in = req_last;
               // A first frame only primes the history; it may still be last.
               if (req_first) begin
                  state_in = req_last ? ST_FINAL : ST_IDLE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.can_load) begin
               cmd.step = 1'b1;
               cmd.tag_last = ~last_ff & status.last_step;
               if (status.last_step) begin
                  state_in = last_ff ? ST_FINAL : ST_IDLE;
               end
            end
         end
         ST_FINAL: begin
            if (status.can_load) begin
               cmd.emit_final = 1'b1;
               cmd.tag_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
   end

endmodule

[rtl/linear_interp_upsampler.sv]
// Linear interpolation upsampler, top level.
// Input words on req_ch carry one frame (left and right sample plus the
// first_frame and last_frame marks); output words on rsp_ch carry one frame
// and last_of_run. Both channels move a word when valid and ready are high.
// The csr_ port writes the interpolation factor (index 0) and the channel count (index 1).
// A frame that is not first yields factor interpolated words between
// the stored frame and itself; a last frame adds itself as one more word.
// Per input word: the block accepts it, divides the frame difference by the
// factor bit-serially, then emits the interpolated words in order.
// The single output register sets one word per cycle while the receiver
// keeps ready high. Input is taken again once the last word sits in the output
// register, even if the receiver has not taken it.
// When the receiver stalls, the output register holds its word and the block
// waits. Reset clears the stored frame to zero, the factor to one and the
// channel count to two, and empties the output register.
// Depends on ipu_pkg, ipu_req_if, ipu_rsp_if, ipu_div, ipu_dp and ipu_ctrl.
module linear_interp_upsampler #(
   parameter int MAX_CHANNELS = ipu_pkg::DEFAULT_MAX_CHANNELS,
   parameter int SAMPLE_BITS = ipu_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   ipu_req_if.sink                         req_ch,
   ipu_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [ipu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ipu_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   ipu_pkg::cmd_type    cmd;
   ipu_pkg::status_type status;
   logic                req_ready;

   ipu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_first(req_ch.first_frame),
      .req_last (req_ch.last_frame),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   ipu_dp #(
      .MAX_CHANNELS(MAX_CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .status          (status),
      .left_sample     (req_ch.left_sample),
      .right_sample    (req_ch.right_sample),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .left_out        (rsp_ch.left_out),
      .right_out       (rsp_ch.right_out),
      .last_of_run     (rsp_ch.last_of_run)
   );

   assign req_ch.ready = req_ready;

`ifndef SYNTHESIS
   // A first frame that is not also last produces nothing, so the block is
   // ready again right away.
   a_first_only_ready: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.first_frame && !req_ch.last_frame)
      |=> req_ch.ready)
      else $error("block not ready after a first frame");

   // Any other interval starts the dividers and blocks the input.
   a_interval_divides: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !req_ch.first_frame)
      |=> (status.div_busy && !req_ch.ready))
      else $error("divider not started for an interval");

   // The controller only emits a word when the output register has room.
   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.emit_final) |-> status.can_load)
      else $error("word emitted into a full output register");
`endif

endmodule

[tb/linear_interp_upsampler_tb.sv]
// Self-checking testbench for linear_interp_upsampler.
// Drives input frames and register writes, predicts every output word, and
// checks them in order. Depends on ipu_pkg, ipu_req_if and ipu_rsp_if.
`timescale 1ns / 1ps

module linear_interp_upsampler_tb;

   localparam int SW = ipu_pkg::DEFAULT_SAMPLE_BITS;
   localparam int FW = ipu_pkg::FACTOR_W;
   localparam int CW = ipu_pkg::CHAN_W;
   // Divider loop plus the largest factor, with some margin.
   localparam int SETTLE_CYCLES = 100;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int FRAME_TARGET = 330;

   typedef struct packed {
      logic signed [SW-1:0] left;
      logic signed [SW-1:0] right;
      logic                 first;
      logic                 last;
   } frame_type;

   typedef struct packed {
      logic signed [SW-1:0] left;
      logic signed [SW-1:0] right;
      logic                 last;
   } out_word_type;

   typedef struct packed {
      logic [FW-1:0] factor;
      logic [CW-1:0] chans;
      frame_type     frame;
      logic          typed;
      out_word_type  word;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [ipu_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ipu_pkg::CSR_DATA_W-1:0] csr_write_data;

   ipu_req_if #(.SAMPLE_BITS(SW)) req_if ();
   ipu_rsp_if #(.SAMPLE_BITS(SW)) rsp_if ();

   linear_interp_upsampler u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow of the block's registers and stored frame.
   logic [FW-1:0] cfg_factor;
   logic [CW-1:0] cfg_channels;
   logic signed [SW-1:0] held_left;
   logic signed [SW-1:0] held_right;

   out_word_type interp_words [0:63];
   out_word_type expected_words [$];
   stim_row_type directed_rows [$];

   int errors = 0;
   int frames_sent = 0;
   int rsp_wait = 0;
   logic req_quiet = 1'b0;
   logic hold_request = 1'b0;

   // Fills interp_words with the words caused by one frame and returns their
   // number; the frame then becomes the stored one.
   function automatic int interpolate_frame(input frame_type f);
      int cur_l, cur_r, base_l, base_r, div, n;
      logic stereo;
      cur_l = $signed(f.left);
      cur_r = $signed(f.right);
      base_l = $signed(held_left);
      base_r = $signed(held_right);
      div = (cfg_factor == '0) ? 1 : int'(cfg_factor);
      // A count of zero means mono, anything above two means stereo.
      stereo = (cfg_channels >= 2);
      n = 0;
      if (!f.first) begin
         for (int k = 0; k < div; k++) begin
            interp_words[n].left = SW'(base_l + ((cur_l - base_l) * k) / div);
            interp_words[n].right = stereo ? SW'(base_r + ((cur_r - base_r) * k) / div) : '0;
            interp_words[n].last = !f.last && (k == div - 1);
            n++;
         end
      end
      if (f.last) begin
         interp_words[n].left = f.left;
         interp_words[n].right = stereo ? f.right : '0;
         interp_words[n].last = 1'b1;
         n++;
      end
      held_left = f.left;
      held_right = f.right;
      return n;
   endfunction

   function automatic logic signed [SW-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(SW-1){1'b0}}};
         1: return {1'b0, {(SW-1){1'b1}}};
         2: return SW'(int'($urandom_range(0, 64)) - 32);
         default: return SW'($urandom);
      endcase
   endfunction

   task automatic add_row(input int factor, input int chans,
                          input int l, input int r, input int first, input int last,
                          input int typed, input int el, input int er, input int elast);
      stim_row_type row;
      row.factor = FW'(factor);
      row.chans = CW'(chans);
      row.frame = '{left: SW'(l), right: SW'(r), first: 1'(first), last: 1'(last)};
      row.typed = 1'(typed);
      row.word = '{left: SW'(el), right: SW'(er), last: 1'(elast)};
      directed_rows.push_back(row);
   endtask

   // Offers one frame after a random gap and waits for it to be taken.
   // A typed word replaces the predicted one; the stored frame moves either way.
   task automatic send_frame(input frame_type f, input logic typed, input out_word_type word);
      int gap, n;
      gap = req_quiet ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.left_sample <= f.left;
      req_if.right_sample <= f.right;
      req_if.first_frame <= f.first;
      req_if.last_frame <= f.last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      n = interpolate_frame(f);
      if (typed) begin
         expected_words.push_back(word);
      end else begin
         for (int i = 0; i < n; i++) expected_words.push_back(interp_words[i]);
      end
      frames_sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [FW-1:0] factor,
                                 input logic [CW-1:0] chans);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index <= ipu_pkg::CSR_FACTOR;
      csr_write_data <= ipu_pkg::CSR_DATA_W'(factor);
      @(posedge clock);
      csr_index <= ipu_pkg::CSR_CHANNELS;
      csr_write_data <= ipu_pkg::CSR_DATA_W'(chans);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_factor = factor;
      cfg_channels = chans;
   endtask

   // Receiver: checks each word taken, then holds ready low for a drawn stretch.
   always @(posedge clock) begin : rsp_side
      int stall;
      out_word_type want;
      static int words_seen = 0;
      static logic rsp_quiet = 1'b0;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_if.ready) begin
         if (rsp_if.valid) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual left %0d right %0d last %0b",
                        $time, rsp_if.left_out, rsp_if.right_out, rsp_if.last_of_run);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_if.left_out !== want.left) begin
                  $display("%0t: left_out expected %0d, actual %0d",
                           $time, want.left, rsp_if.left_out);
                  errors++;
               end
               if (rsp_if.right_out !== want.right) begin
                  $display("%0t: right_out expected %0d, actual %0d",
                           $time, want.right, rsp_if.right_out);
                  errors++;
               end
               if (rsp_if.last_of_run !== want.last) begin
                  $display("%0t: last_of_run expected %0b, actual %0b",
                           $time, want.last, rsp_if.last_of_run);
                  errors++;
               end
            end
            words_seen++;
            if (words_seen % 48 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
            stall = rsp_quiet ? 0 : $urandom_range(0, 13);
            if (hold_request) begin
               stall = LONG_HOLD_CYCLES;
               hold_request = 1'b0;
            end
            rsp_wait <= stall;
            rsp_if.ready <= (stall == 0);
         end
      end else if (rsp_wait > 1) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_wait <= 0;
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      frame_type f;
      logic [FW-1:0] factor;
      logic [CW-1:0] chans;
      int phase_len, buf_len, phase;
      logic noisy;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.left_sample = '0;
      req_if.right_sample = '0;
      req_if.first_frame = 1'b0;
      req_if.last_frame = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = ipu_pkg::CSR_FACTOR;
      csr_write_data = '0;
      cfg_factor = ipu_pkg::FACTOR_RESET;
      cfg_channels = ipu_pkg::CHANNELS_RESET;
      held_left = '0;
      held_right = '0;

      //       fac  ch  left    right   first last typed  exp_l   exp_r   exp_last
      // Right after reset the interval starts from the all-zero stored frame.
      add_row(1,   2,  1000,   -1000,  0,    0,   1,     0,      0,      1);
      add_row(1,   2,  32767,  -32768, 0,    0,   1,     1000,   -1000,  1);
      add_row(1,   2,  -32768, 32767,  1,    1,   1,     -32768, 32767,  1);
      add_row(1,   2,  5,      -5,     1,    0,   0,     0,      0,      0);
      add_row(1,   2,  32767,  -32768, 0,    1,   0,     0,      0,      0);
      add_row(4,   2,  -32768, 32767,  0,    0,   0,     0,      0,      0);
      add_row(4,   2,  -7,     7,      0,    0,   0,     0,      0,      0);
      add_row(4,   2,  0,      0,      0,    1,   0,     0,      0,      0);
      add_row(63,  2,  32767,  -32768, 0,    0,   0,     0,      0,      0);
      add_row(63,  2,  -32768, 32767,  0,    1,   0,     0,      0,      0);
      // Factor zero acts as one and a channel count of zero as mono.
      add_row(0,   0,  1234,   -4321,  0,    0,   1,     -32768, 0,      1);
      add_row(0,   0,  -1,     -1,     1,    1,   1,     -1,     0,      1);
      // A count of three is clamped to stereo.
      add_row(3,   3,  300,    -300,   0,    0,   0,     0,      0,      0);
      add_row(3,   3,  -301,   301,    0,    1,   0,     0,      0,      0);
      add_row(5,   1,  100,    32767,  0,    0,   0,     0,      0,      0);
      add_row(5,   1,  -100,   -32768, 1,    0,   0,     0,      0,      0);
      add_row(5,   1,  32767,  12345,  0,    1,   0,     0,      0,      0);
      // The right sample stored in mono is the base of the next stereo interval.
      add_row(2,   2,  0,      0,      0,    0,   0,     0,      0,      0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].factor != cfg_factor || directed_rows[i].chans != cfg_channels)
            write_settings(directed_rows[i].factor, directed_rows[i].chans);
         send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].word);
      end

      phase = 0;
      while (frames_sent < FRAME_TARGET) begin
         case ($urandom_range(0, 9))
            0: factor = '0;
            1: factor = 6'd63;
            2: factor = FW'($urandom_range(9, 62));
            default: factor = FW'($urandom_range(1, 8));
         endcase
         chans = CW'($urandom_range(0, 3));
         write_settings(factor, chans);
         phase_len = (factor > 8) ? $urandom_range(3, 8) : $urandom_range(15, 40);
         req_quiet = ($urandom_range(0, 3) == 0);
         // Early on, stall the receiver for a long stretch while frames keep coming.
         if (phase == 2) hold_request = 1'b1;
         while (phase_len > 0 && frames_sent < FRAME_TARGET) begin
            buf_len = $urandom_range(1, 10);
            noisy = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < buf_len; i++) begin
               f.left = draw_sample();
               f.right = draw_sample();
               f.first = noisy ? 1'($urandom) : (i == 0);
               f.last = noisy ? 1'($urandom) : (i == buf_len - 1);
               send_frame(f, 1'b0, '0);
               phase_len--;
            end
            if ($urandom_range(0, 14) == 0) drain_results();
         end
         phase++;
      end

      drain_results();
      if (errors == 0) begin
         $display("linear_interp_upsampler_tb: PASS");
      end else begin
         $display("linear_interp_upsampler_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
      $display("linear_interp_upsampler_tb: FAIL");
      $finish;
   end

endmodule
